// ===== src/fup_pkg.sv =====
// Shared types, constants and the class-to-unit table of the unit pool allocator.
package fup_pkg;

  localparam int NUM_UNITS = 5;
  localparam int UNIT_W    = $clog2(NUM_UNITS);
  localparam int CLASS_W   = 4;
  localparam int KIND_W    = 2;
  localparam int BUSY_W    = 8;
  localparam int LAT_W     = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_GET    = 2'd1,
    KIND_ALLOC  = 2'd2,
    KIND_OCCUPY = 2'd3
  } fup_kind_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_ALU    = 4'd0,
    CLS_BRANCH = 4'd1,
    CLS_MULT   = 4'd2,
    CLS_DIV    = 4'd3,
    CLS_RD     = 4'd4,
    CLS_WR     = 4'd5,
    CLS_FPBR   = 4'd6,
    CLS_FADD   = 4'd7,
    CLS_FCMP   = 4'd8,
    CLS_FCVT   = 4'd9,
    CLS_FMUL   = 4'd10,
    CLS_FDIV   = 4'd11,
    CLS_FSQRT  = 4'd12
  } fup_class_e;

  // One row of the class table; second unit used only when two_units is set.
  typedef struct packed {
    logic              valid;
    logic              two_units;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic [LAT_W-1:0]  op_lat;
    logic [LAT_W-1:0]  iss_lat;
  } fup_class_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } fup_cmd_t;

  function automatic fup_class_t fup_class_lookup(logic [CLASS_W-1:0] cls);
    fup_class_t e;
    e = '0;
    e.valid = 1'b1;
    case (cls)
      CLS_ALU: begin
        e.two_units = 1'b1; e.unit0 = 3'd0; e.unit1 = 3'd1;
        e.op_lat = 4'd1; e.iss_lat = 4'd1;
      end
      CLS_BRANCH: begin
        e.unit0 = 3'd0; e.op_lat = 4'd1; e.iss_lat = 4'd1;
      end
      CLS_MULT: begin
        e.unit0 = 3'd1; e.op_lat = 4'd4; e.iss_lat = 4'd1;
      end
      CLS_DIV: begin
        e.unit0 = 3'd1; e.op_lat = 4'd13; e.iss_lat = 4'd12;
      end
      CLS_RD, CLS_WR: begin
        e.unit0 = 3'd2; e.op_lat = 4'd4; e.iss_lat = 4'd1;
      end
      CLS_FPBR, CLS_FADD, CLS_FCMP, CLS_FCVT: begin
        e.unit0 = 3'd3; e.op_lat = 4'd3; e.iss_lat = 4'd1;
      end
      CLS_FMUL, CLS_FDIV, CLS_FSQRT: begin
        e.unit0 = 3'd4; e.op_lat = 4'd4; e.iss_lat = 4'd1;
      end
      default: begin
        e = '0;
      end
    endcase
    return e;
  endfunction

endpackage

// ===== src/fup_ctrl.sv =====
// Controller state machine: accepts a request, runs it in the execute state, strobes the result.
module fup_ctrl
  import fup_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output fup_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = start_i && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_EXEC);

endmodule

// ===== src/fup_datapath.sv =====
// Datapath: busy counts, allocation stamps, stamp counter and result registers.
module fup_datapath
  import fup_pkg::*;
#(
  parameter int STAMP_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fup_cmd_t           cmd_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [CLASS_W-1:0] op_class_i,
  input  logic [UNIT_W-1:0]  unit_select_i,
  input  logic [BUSY_W-1:0]  busy_cycles_i,
  output logic               found_o,
  output logic [UNIT_W-1:0]  unit_index_o,
  output logic [LAT_W-1:0]   op_latency_o,
  output logic [LAT_W-1:0]   issue_latency_o
);

  // captured request
  logic [KIND_W-1:0]  kind_q;
  logic [CLASS_W-1:0] class_q;
  logic [UNIT_W-1:0]  sel_q;
  logic [BUSY_W-1:0]  cycles_q;

  logic [BUSY_W-1:0]     busy_q  [NUM_UNITS];
  logic [BUSY_W-1:0]     busy_d  [NUM_UNITS];
  logic [STAMP_BITS-1:0] stamp_q [NUM_UNITS];
  logic [STAMP_BITS-1:0] stamp_d [NUM_UNITS];
  logic [STAMP_BITS-1:0] counter_q, counter_d;

  logic              found_q, found_d;
  logic [UNIT_W-1:0] unit_q, unit_d;
  logic [LAT_W-1:0]  oplat_q, oplat_d;
  logic [LAT_W-1:0]  isslat_q, isslat_d;

  fup_class_t        entry;
  logic [UNIT_W-1:0] pick_unit;

  assign entry = fup_class_lookup(class_q);

  always_comb begin
    busy_d    = busy_q;
    stamp_d   = stamp_q;
    counter_d = counter_q;
    found_d   = 1'b0;
    unit_d    = '0;
    oplat_d   = '0;
    isslat_d  = '0;
    pick_unit = entry.unit0;
    case (kind_q)
      KIND_TICK: begin
        for (int i = 0; i < NUM_UNITS; i++) begin
          if (busy_q[i] != '0) busy_d[i] = busy_q[i] - BUSY_W'(1);
        end
      end
      KIND_OCCUPY: begin
        if (sel_q < UNIT_W'(NUM_UNITS)) busy_d[sel_q] = cycles_q;
      end
      KIND_GET: begin
        if (entry.valid) begin
          if (busy_q[entry.unit0] == '0) begin
            found_d = 1'b1;
          end else if (entry.two_units && busy_q[entry.unit1] == '0) begin
            found_d   = 1'b1;
            pick_unit = entry.unit1;
          end
        end
      end
      KIND_ALLOC: begin
        if (entry.valid) begin
          found_d = 1'b1;
          // oldest stamp wins, tie to the lower unit
          if (entry.two_units && (stamp_q[entry.unit1] < stamp_q[entry.unit0]))
            pick_unit = entry.unit1;
          stamp_d[pick_unit] = counter_q;
          counter_d          = counter_q + STAMP_BITS'(1);
        end
      end
      default: begin
      end
    endcase
    if (found_d) begin
      unit_d   = pick_unit;
      oplat_d  = entry.op_lat;
      isslat_d = entry.iss_lat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      class_q  <= op_class_i;
      sel_q    <= unit_select_i;
      cycles_q <= busy_cycles_i;
    end
    if (cmd_i.execute) begin
      found_q  <= found_d;
      unit_q   <= unit_d;
      oplat_q  <= oplat_d;
      isslat_q <= isslat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        busy_q[i]  <= '0;
        stamp_q[i] <= '0;
      end
      counter_q <= '0;
    end else if (cmd_i.execute) begin
      busy_q    <= busy_d;
      stamp_q   <= stamp_d;
      counter_q <= counter_d;
    end
  end

  assign found_o         = found_q;
  assign unit_index_o    = unit_q;
  assign op_latency_o    = oplat_q;
  assign issue_latency_o = isslat_q;

endmodule

// ===== src/functional_unit_pool_allocator.sv =====
// Top level of the functional unit pool allocator: controller plus datapath.
// Result: a request taken on start_i is captured, then run in the execute state; its result
// is registered and strobed on done_o for one cycle; the receiver cannot stall it.
// Requests: each is captured, then run in the execute state that reads and updates the
// busy/stamp registers; start is ignored while busy_o is high and taken while done_o is high.
// Reset: rst_ni asynchronous active low clears busy counts, stamps and stamp counter.
module functional_unit_pool_allocator
  import fup_pkg::*;
#(
  parameter int STAMP_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [CLASS_W-1:0] op_class_i,
  input  logic [UNIT_W-1:0]  unit_select_i,
  input  logic [BUSY_W-1:0]  busy_cycles_i,
  output logic               done_o,
  output logic               found_o,
  output logic [UNIT_W-1:0]  unit_index_o,
  output logic [LAT_W-1:0]   op_latency_o,
  output logic [LAT_W-1:0]   issue_latency_o
);

  fup_cmd_t cmd;

  fup_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  fup_datapath #(
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .op_class_i      (op_class_i),
    .unit_select_i   (unit_select_i),
    .busy_cycles_i   (busy_cycles_i),
    .found_o         (found_o),
    .unit_index_o    (unit_index_o),
    .op_latency_o    (op_latency_o),
    .issue_latency_o (issue_latency_o)
  );

endmodule
